### sv/irs_pkg.sv
// shared types, step addresses and symbol tables for the roman numeral serializer
package irs_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned SYM_W   = 7;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned DIG_W   = 4;

  localparam logic [LIMIT_W-1:0] LOWER_RESET  = 12'd1000;
  localparam logic [LIMIT_W-1:0] UPPER_RESET  = 12'd3000;
  localparam logic [VALUE_W-1:0] NUMERAL_MIN  = 16'd1;
  localparam logic [VALUE_W-1:0] NUMERAL_MAX  = 16'd3999;

  localparam logic CFG_LOWER = 1'b0;
  localparam logic CFG_UPPER = 1'b1;

  // scale of a digit position
  typedef enum logic [1:0] {
    SC_ONES  = 2'd0,
    SC_TENS  = 2'd1,
    SC_HUNDS = 2'd2,
    SC_THOUS = 2'd3
  } scale_t;

  typedef enum logic [2:0] {
    OP_CHECK = 3'd0,
    OP_MLOOP = 3'd1,
    OP_COUNT = 3'd2,
    OP_PRE   = 3'd3,
    OP_FIVE  = 3'd4,
    OP_ONES  = 3'd5,
    OP_END   = 3'd6,
    OP_IDLE  = 3'd7
  } op_t;

  typedef struct packed {
    op_t               op;
    scale_t            scale;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MLOOP   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_H_COUNT = 4'd2;
  localparam logic [STEP_W-1:0] STEP_H_PRE   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_H_FIVE  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_H_ONES  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_T_COUNT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_T_PRE   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_T_FIVE  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_T_ONES  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_O_COUNT = 4'd10;
  localparam logic [STEP_W-1:0] STEP_O_PRE   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_O_FIVE  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_O_ONES  = 4'd13;
  localparam logic [STEP_W-1:0] STEP_END     = 4'd14;
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd15;

  localparam logic [SYM_W-1:0] SYM_M = 7'h4D;
  localparam logic [SYM_W-1:0] SYM_D = 7'h44;
  localparam logic [SYM_W-1:0] SYM_C = 7'h43;
  localparam logic [SYM_W-1:0] SYM_L = 7'h4C;
  localparam logic [SYM_W-1:0] SYM_X = 7'h58;
  localparam logic [SYM_W-1:0] SYM_V = 7'h56;
  localparam logic [SYM_W-1:0] SYM_I = 7'h49;

  function automatic logic [LIMIT_W-1:0] unit_of(scale_t sc);
    case (sc)
      SC_ONES:  unit_of = 12'd1;
      SC_TENS:  unit_of = 12'd10;
      SC_HUNDS: unit_of = 12'd100;
      default:  unit_of = 12'd1000;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] one_of(scale_t sc);
    case (sc)
      SC_ONES:  one_of = SYM_I;
      SC_TENS:  one_of = SYM_X;
      SC_HUNDS: one_of = SYM_C;
      default:  one_of = SYM_M;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] five_of(scale_t sc);
    case (sc)
      SC_ONES:  five_of = SYM_V;
      SC_TENS:  five_of = SYM_L;
      default:  five_of = SYM_D;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] ten_of(scale_t sc);
    case (sc)
      SC_ONES:  ten_of = SYM_X;
      SC_TENS:  ten_of = SYM_C;
      default:  ten_of = SYM_M;
    endcase
  endfunction

endpackage

### sv/irs_if.sv
// valid/ready channel interfaces for number input and character output
interface irs_in_if;
  logic                        valid;
  logic                        ready;
  logic [irs_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface irs_out_if;
  logic                      valid;
  logic                      ready;
  logic [irs_pkg::SYM_W-1:0] symbol;
  logic                      error;
  logic                      last;

  modport source (output valid, output symbol, output error, output last, input ready);
  modport sink   (input valid, input symbol, input error, input last, output ready);
endinterface

### sv/irs_ucode_rom.sv
// microcode rom: one control word per sequencer step
module irs_ucode_rom (
  input  logic [irs_pkg::STEP_W-1:0] addr,
  output irs_pkg::ctrl_t             word
);
  import irs_pkg::*;

  always_comb begin
    case (addr)
      STEP_CHECK:   word = '{op: OP_CHECK, scale: SC_THOUS, target: STEP_MLOOP};
      STEP_MLOOP:   word = '{op: OP_MLOOP, scale: SC_THOUS, target: STEP_H_COUNT};
      STEP_H_COUNT: word = '{op: OP_COUNT, scale: SC_HUNDS, target: STEP_H_PRE};
      STEP_H_PRE:   word = '{op: OP_PRE,   scale: SC_HUNDS, target: STEP_H_FIVE};
      STEP_H_FIVE:  word = '{op: OP_FIVE,  scale: SC_HUNDS, target: STEP_H_ONES};
      STEP_H_ONES:  word = '{op: OP_ONES,  scale: SC_HUNDS, target: STEP_T_COUNT};
      STEP_T_COUNT: word = '{op: OP_COUNT, scale: SC_TENS,  target: STEP_T_PRE};
      STEP_T_PRE:   word = '{op: OP_PRE,   scale: SC_TENS,  target: STEP_T_FIVE};
      STEP_T_FIVE:  word = '{op: OP_FIVE,  scale: SC_TENS,  target: STEP_T_ONES};
      STEP_T_ONES:  word = '{op: OP_ONES,  scale: SC_TENS,  target: STEP_O_COUNT};
      STEP_O_COUNT: word = '{op: OP_COUNT, scale: SC_ONES,  target: STEP_O_PRE};
      STEP_O_PRE:   word = '{op: OP_PRE,   scale: SC_ONES,  target: STEP_O_FIVE};
      STEP_O_FIVE:  word = '{op: OP_FIVE,  scale: SC_ONES,  target: STEP_O_ONES};
      STEP_O_ONES:  word = '{op: OP_ONES,  scale: SC_ONES,  target: STEP_END};
      STEP_END:     word = '{op: OP_END,   scale: SC_ONES,  target: STEP_IDLE};
      default:      word = '{op: OP_IDLE,  scale: SC_ONES,  target: STEP_CHECK};
    endcase
  end

endmodule

### sv/integer_to_roman_serializer_unit.sv
// top level: microcoded integer to roman numeral serializer
//
//  channel  dir  handshake       payload
//  in_ch    in   valid / ready   value[15:0]
//  out_ch   out  valid / ready   symbol[6:0], error, last
//  cfg      in   cfg_we          cfg_index[0], cfg_data[11:0]
//
//  one item at a time; a new number is taken only when the sequencer is idle
//  an item runs check, the thousands loop, then count, prefix, five and ones
//  steps for hundreds, tens and ones, then end; a rejected value ends at the
//  check step with an error word; reset (rst_n low, synchronous) sets the
//  limits to 1000 and 3000 and idles the sequencer
//  a full output word that is not taken holds the sequencer on emitting steps
module integer_to_roman_serializer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  irs_in_if.sink                       in_ch,
  irs_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [irs_pkg::LIMIT_W-1:0]  cfg_data
);
  import irs_pkg::*;

  logic [LIMIT_W-1:0] lower_r, upper_r;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [LIMIT_W-1:0] rem_r, rem_nxt;
  logic [DIG_W-1:0]   dig_r, dig_nxt;
  logic               bad_r, bad_nxt;
  logic [SYM_W-1:0]   pend_sym_r, pend_sym_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_sym_r;
  logic               out_err_r, out_last_r;

  ctrl_t              ctrl;
  logic [LIMIT_W-1:0] unit;
  logic               emit, push, push_err, push_last, stall, accept;
  logic [SYM_W-1:0]   emit_sym, push_sym;

  irs_ucode_rom u_rom (
    .addr (step_r),
    .word (ctrl)
  );

  assign unit         = unit_of(ctrl.scale);
  assign in_ch.ready  = (step_r == STEP_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.symbol = out_sym_r;
  assign out_ch.error  = out_err_r;
  assign out_ch.last   = out_last_r;

  always_comb begin
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    dig_nxt        = dig_r;
    bad_nxt        = bad_r;
    pend_sym_nxt   = pend_sym_r;
    pend_valid_nxt = pend_valid_r;
    emit           = 1'b0;
    emit_sym       = one_of(ctrl.scale);
    push           = 1'b0;
    push_sym       = pend_sym_r;
    push_err       = 1'b0;
    push_last      = 1'b0;
    case (ctrl.op)
      OP_IDLE: begin
        if (accept) begin
          rem_nxt  = in_ch.value[LIMIT_W-1:0];
          bad_nxt  = (in_ch.value < {{(VALUE_W-LIMIT_W){1'b0}}, lower_r}) ||
                     (in_ch.value > {{(VALUE_W-LIMIT_W){1'b0}}, upper_r}) ||
                     (in_ch.value < NUMERAL_MIN) || (in_ch.value > NUMERAL_MAX);
          step_nxt = ctrl.target;
        end
      end
      OP_CHECK: begin
        if (bad_r) begin
          push      = 1'b1;
          push_sym  = '0;
          push_err  = 1'b1;
          push_last = 1'b1;
          step_nxt  = STEP_IDLE;
        end else begin
          step_nxt = ctrl.target;
        end
      end
      OP_MLOOP: begin
        if (rem_r >= unit) begin
          emit    = 1'b1;
          rem_nxt = rem_r - unit;
        end else begin
          step_nxt = ctrl.target;
        end
      end
      OP_COUNT: begin
        if (rem_r >= unit) begin
          rem_nxt = rem_r - unit;
          dig_nxt = dig_r + DIG_W'(1);
        end else begin
          step_nxt = ctrl.target;
        end
      end
      OP_PRE: begin
        // four and nine lead with a one, then continue as five and ten
        if (dig_r == DIG_W'(4) || dig_r == DIG_W'(9)) begin
          emit    = 1'b1;
          dig_nxt = dig_r + DIG_W'(1);
        end
        step_nxt = ctrl.target;
      end
      OP_FIVE: begin
        if (dig_r == DIG_W'(10)) begin
          emit     = 1'b1;
          emit_sym = ten_of(ctrl.scale);
          dig_nxt  = '0;
        end else if (dig_r >= DIG_W'(5)) begin
          emit     = 1'b1;
          emit_sym = five_of(ctrl.scale);
          dig_nxt  = dig_r - DIG_W'(5);
        end
        step_nxt = ctrl.target;
      end
      OP_ONES: begin
        if (dig_r != '0) begin
          emit    = 1'b1;
          dig_nxt = dig_r - DIG_W'(1);
        end else begin
          step_nxt = ctrl.target;
        end
      end
      OP_END: begin
        push           = pend_valid_r;
        push_last      = 1'b1;
        pend_valid_nxt = 1'b0;
        step_nxt       = ctrl.target;
      end
      default: begin
        step_nxt = STEP_IDLE;
      end
    endcase
    // each new character pushes out the one held before it
    if (emit) begin
      push           = pend_valid_r;
      pend_sym_nxt   = emit_sym;
      pend_valid_nxt = 1'b1;
    end
  end

  assign stall = push && out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r      <= LOWER_RESET;
      upper_r      <= UPPER_RESET;
      step_r       <= STEP_IDLE;
      dig_r        <= '0;
      bad_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOWER: lower_r <= cfg_data;
          CFG_UPPER: upper_r <= cfg_data;
          default:   upper_r <= upper_r;
        endcase
      end
      if (!stall) begin
        step_r       <= step_nxt;
        dig_r        <= dig_nxt;
        bad_r        <= bad_nxt;
        pend_valid_r <= pend_valid_nxt;
      end
      if (push && !stall) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      rem_r      <= rem_nxt;
      pend_sym_r <= pend_sym_nxt;
    end
    if (push && !stall) begin
      out_sym_r  <= push_sym;
      out_err_r  <= push_err;
      out_last_r <= push_last;
    end
  end

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (step_r == STEP_CHECK))
    else $error("accepted number did not start at the check step");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_last_r && out_sym_r == '0))
    else $error("error word must be last with a zero symbol");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_IDLE) |-> (dig_r == '0 && !pend_valid_r))
    else $error("sequencer idle with leftover digit or held character");

  a_end_has_char: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_END) |-> pend_valid_r)
    else $error("end step reached with no character held");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dig_r <= DIG_W'(10)))
    else $error("digit register out of range");

endmodule
